[src/murmurhash2_hasher_defines.svh]
// ----------------------------------------------------------------------------
// murmurhash2_hasher_defines
// assertion macros used by the hasher top level
// ----------------------------------------------------------------------------
`ifndef MURMURHASH2_HASHER_DEFINES_SVH
`define MURMURHASH2_HASHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent holds in this cycle, consequent in the same cycle
`define MMH2_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define MMH2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MMH2_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MMH2_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/mmh2_pkg.sv]
// ----------------------------------------------------------------------------
// mmh2_pkg
// constants and shared types of the murmurhash2 hasher
// ----------------------------------------------------------------------------
package mmh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd42;

    // request to the shared constant multiplier
    typedef struct packed {
        logic        en;
        logic [31:0] op;
    } t_mul_req;

    // sequencer status seen by the top level
    typedef struct packed {
        logic fin;
    } t_seq_status;

endpackage

[src/mmh2_key_if.sv]
// ----------------------------------------------------------------------------
// mmh2_key_if
// key block channel: valid, ready and one block of key bytes
// ----------------------------------------------------------------------------
interface mmh2_key_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_block;
    logic [2:0]  byte_count;
    logic        key_start;
    logic        key_last;
    logic [15:0] key_length;

    modport source (
        output valid, data_block, byte_count, key_start, key_last, key_length,
        input  ready
    );
    modport sink (
        input  valid, data_block, byte_count, key_start, key_last, key_length,
        output ready
    );
endinterface

[src/mmh2_hash_if.sv]
// ----------------------------------------------------------------------------
// mmh2_hash_if
// result channel: valid, ready and the finalized hash
// ----------------------------------------------------------------------------
interface mmh2_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

[src/mmh2_mul.sv]
// ----------------------------------------------------------------------------
// mmh2_mul
// shared multiplier by the mixing constant, registered product
// ----------------------------------------------------------------------------
module mmh2_mul (
    input  logic              i_clk,
    input  mmh2_pkg::t_mul_req i_req,
    output logic [31:0]       o_prod
);
    import mmh2_pkg::*;

    logic [31:0] n_full;
    logic [31:0] r_prod;

    // only the low word of the product is kept
    assign n_full = i_req.op * MIX_MUL;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_full;
        end
    end

    assign o_prod = r_prod;
endmodule

[src/mmh2_seq.sv]
// ----------------------------------------------------------------------------
// mmh2_seq
// sequencer and hash registers, drives the shared multiplier
// ----------------------------------------------------------------------------
module mmh2_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_seed,
    input  logic [31:0]           i_prod,
    output mmh2_pkg::t_mul_req    o_req,
    output mmh2_pkg::t_seq_status o_status,
    mmh2_key_if.sink              i_key_if,
    mmh2_hash_if.source           o_hash_if
);
    import mmh2_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MH   = 3'd1;
    localparam logic [2:0] S_MK1  = 3'd2;
    localparam logic [2:0] S_MK2  = 3'd3;
    localparam logic [2:0] S_FOLD = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;
    localparam logic [2:0] S_PASS = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [31:0] r_h, n_h;
    logic [31:0] r_k, n_k;
    logic        r_last, n_last;
    logic        r_tail, n_tail;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_res, n_res;

    logic [31:0] h0;
    logic [31:0] tail_bytes;
    logic [31:0] hnew;
    logic [31:0] kmix;

    assign h0 = i_key_if.key_start ? (i_seed ^ {16'd0, i_key_if.key_length}) : r_h;
    assign kmix = i_prod ^ (i_prod >> MIX_SHIFT);

    always_comb begin
        case (i_key_if.byte_count)
            3'd1:    tail_bytes = {24'd0, i_key_if.data_block[7:0]};
            3'd2:    tail_bytes = {16'd0, i_key_if.data_block[15:0]};
            3'd3:    tail_bytes = {8'd0, i_key_if.data_block[23:0]};
            default: tail_bytes = 32'd0;
        endcase
    end

    // hash after the block is folded in, by the path taken
    always_comb begin
        case (r_state)
            S_FOLD:  hnew = r_h ^ i_prod;
            S_TAIL:  hnew = i_prod;
            default: hnew = r_h;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_k      = r_k;
        n_last   = r_last;
        n_tail   = r_tail;
        n_ovalid = r_ovalid && !o_hash_if.ready;
        n_res    = r_res;
        o_req.en = 1'b1;
        o_req.op = r_h;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_key_if.valid) begin
                    n_last = i_key_if.key_last;
                    if (i_key_if.byte_count[2]) begin
                        n_h     = h0;
                        n_k     = i_key_if.data_block;
                        n_tail  = 1'b0;
                        n_state = S_MH;
                    end else if (i_key_if.byte_count != 3'd0) begin
                        n_h     = h0 ^ tail_bytes;
                        n_tail  = 1'b1;
                        n_state = S_MH;
                    end else begin
                        n_h     = h0;
                        n_state = S_PASS;
                    end
                end
            end
            S_MH: begin
                o_req.op = r_h;
                n_state  = r_tail ? S_TAIL : S_MK1;
            end
            S_MK1: begin
                // product here is h * m
                n_h      = i_prod;
                o_req.op = r_k;
                n_state  = S_MK2;
            end
            S_MK2: begin
                o_req.op = kmix;
                n_state  = S_FOLD;
            end
            S_FOLD, S_TAIL, S_PASS: begin
                n_h      = hnew;
                o_req.op = hnew ^ (hnew >> FIN_SHIFT_A);
                n_state  = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                // hold the product until the output register is free
                o_req.en = 1'b0;
                if (!r_ovalid || o_hash_if.ready) begin
                    n_ovalid = 1'b1;
                    n_res    = i_prod ^ (i_prod >> FIN_SHIFT_B);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_h      <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_h      <= n_h;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_last <= n_last;
        r_tail <= n_tail;
        r_res  <= n_res;
    end

    assign i_key_if.ready       = (r_state == S_IDLE);
    assign o_hash_if.valid      = r_ovalid;
    assign o_hash_if.hash_value = r_res;
    assign o_status.fin         = (r_state == S_FIN);
endmodule

[src/murmurhash2_hasher.sv]
// ----------------------------------------------------------------------------
// murmurhash2_hasher
// streaming 32-bit murmurhash2 over little-endian key blocks
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_key_if   in   valid/ready    data_block, byte_count, key_start,
//                                 key_last, key_length
//  o_hash_if  out  valid/ready    hash_value
//  cfg        in   i_cfg_we       i_cfg_wdata (hash seed)
//
//  one multiplier by 0x5bd1e995 is shared by every multiply of an item
//  after its transfer in S_IDLE, a full block passes S_MH, S_MK1, S_MK2 and
//  S_FOLD, a short tail S_MH and S_TAIL, an empty block S_PASS; a last item
//  then loads the output register in S_FIN, waiting there while the sink
//  stalls with it full; one product per cycle, in sequence, none in S_FIN
//  synchronous active-low reset: seed back to 42, running hash to zero
//  the result sits in an output register; a stalled sink holds only a
//  following last item, other items keep flowing
// ----------------------------------------------------------------------------
`include "murmurhash2_hasher_defines.svh"

module murmurhash2_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    mmh2_key_if.sink    i_key_if,
    mmh2_hash_if.source o_hash_if
);
    import mmh2_pkg::*;

    logic [31:0] r_seed;
    logic [31:0] prod;
    t_mul_req    mul_req;
    t_seq_status seq_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    mmh2_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    mmh2_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed    (r_seed),
        .i_prod    (prod),
        .o_req     (mul_req),
        .o_status  (seq_status),
        .i_key_if  (i_key_if),
        .o_hash_if (o_hash_if)
    );

    // every transfer starts work, so ready is low in the next cycle
    `MMH2_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n,
        i_key_if.valid && i_key_if.ready, !i_key_if.ready,
        "ready stayed high after an input transfer")

    // a result only appears out of the finalize step
    `MMH2_ASSERT_SAME(a_result_from_fin, i_clk, i_rst_n,
        $rose(o_hash_if.valid), $past(seq_status.fin),
        "result valid without a finalize step")

    // finalize with a free output register loads it
    `MMH2_ASSERT_NEXT(a_fin_loads_output, i_clk, i_rst_n,
        seq_status.fin && !o_hash_if.valid, o_hash_if.valid && !seq_status.fin,
        "finalize did not load the output register")

endmodule
